### rtl/sdtq_pkg.sv
// shared types and constants for the sorted deadline timer queue
package sdtq_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int SLOT_W      = 4;
  localparam int LINK_W      = SLOT_W + 1;
  localparam int TIME_W      = 64;
  localparam int KIND_W      = 2;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int GUARD_W     = $clog2(NUM_TIMERS + 1);

  localparam logic [LINK_W-1:0] NIL = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ = 2'd0,
    KIND_DEQ = 2'd1,
    KIND_CHK = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_LINK_B,
    S_UNL_A,
    S_UNL_B
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EMIT_REFUSE,
    OP_EMIT_ZERO,
    OP_EMIT_HEAD,
    OP_ENQ_INIT,
    OP_WALK_STEP,
    OP_LINK_A,
    OP_LINK_B,
    OP_DEQ_IDLE,
    OP_DEQ_GRAB,
    OP_CHK_GRAB,
    OP_UNL_A,
    OP_UNL_B
  } dp_op_e;

  typedef enum logic [1:0] {
    RD_SLOT,
    RD_CUR,
    RD_HEAD
  } rd_sel_e;

  typedef struct packed {
    dp_op_e  op;
    rd_sel_e rd_sel;
  } sdtq_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              slot_ok;
    logic              slot_act;
    logic              walk_more;
    logic              expire_head;
    logic              chain_more;
  } sdtq_stat_t;

endpackage

### rtl/sdtq_ctrl.sv
// sequencer for the sorted deadline timer queue
module sdtq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sdtq_pkg::sdtq_stat_t stat,
  output sdtq_pkg::sdtq_cmd_t  cmd
);
  import sdtq_pkg::*;

  state_e state_r;
  state_e state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = OP_NONE;
    cmd.rd_sel = RD_HEAD;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.kind)
          KIND_ENQ: begin
            cmd.rd_sel = RD_SLOT;
            if (!stat.slot_ok || stat.slot_act) begin
              cmd.op    = OP_EMIT_REFUSE;
              state_nxt = S_IDLE;
            end else begin
              cmd.op    = OP_ENQ_INIT;
              state_nxt = S_WALK;
            end
          end
          KIND_DEQ: begin
            cmd.rd_sel = RD_SLOT;
            if (!stat.slot_ok) begin
              cmd.op    = OP_EMIT_ZERO;
              state_nxt = S_IDLE;
            end else if (!stat.slot_act) begin
              cmd.op    = OP_DEQ_IDLE;
              state_nxt = S_IDLE;
            end else begin
              cmd.op    = OP_DEQ_GRAB;
              state_nxt = S_UNL_A;
            end
          end
          KIND_CHK: begin
            cmd.rd_sel = RD_HEAD;
            if (stat.expire_head) begin
              cmd.op    = OP_CHK_GRAB;
              state_nxt = S_UNL_A;
            end else begin
              cmd.op    = OP_EMIT_HEAD;
              state_nxt = S_IDLE;
            end
          end
          default: begin
            cmd.op    = OP_EMIT_ZERO;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_WALK: begin
        cmd.rd_sel = RD_CUR;
        if (stat.walk_more) begin
          cmd.op = OP_WALK_STEP;
        end else begin
          cmd.op    = OP_LINK_A;
          state_nxt = S_LINK_B;
        end
      end
      S_LINK_B: begin
        cmd.op    = OP_LINK_B;
        state_nxt = S_IDLE;
      end
      S_UNL_A: begin
        cmd.op    = OP_UNL_A;
        state_nxt = S_UNL_B;
      end
      S_UNL_B: begin
        cmd.op    = OP_UNL_B;
        state_nxt = stat.chain_more ? S_UNL_A : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

### rtl/sdtq_dpath.sv
// slot storage, linked list and result registers of the timer queue
module sdtq_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sdtq_pkg::sdtq_cmd_t          cmd,
  output sdtq_pkg::sdtq_stat_t         stat,
  input  logic [sdtq_pkg::KIND_W-1:0]  in_kind,
  input  logic [sdtq_pkg::SLOT_W-1:0]  in_slot,
  input  logic [sdtq_pkg::TIME_W-1:0]  in_deadline,
  input  logic [sdtq_pkg::TIME_W-1:0]  in_now,
  output logic                         out_valid,
  output logic                         out_expired_valid,
  output logic [sdtq_pkg::SLOT_W-1:0]  out_expired_slot,
  output logic                         out_program_timer,
  output logic [sdtq_pkg::TIME_W-1:0]  out_timer_deadline,
  output logic [sdtq_pkg::TIME_W-1:0]  out_removed_time,
  output logic                         out_refused,
  output logic                         out_last
);
  import sdtq_pkg::*;

  // list storage
  logic [TIME_W-1:0] dl_r     [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] wr_r, wr_nxt;
  logic [NUM_TIMERS-1:0] act_r, act_nxt;
  logic [LINK_W-1:0] next_r   [NUM_TIMERS];
  logic [LINK_W-1:0] next_nxt [NUM_TIMERS];
  logic [LINK_W-1:0] prev_r   [NUM_TIMERS];
  logic [LINK_W-1:0] prev_nxt [NUM_TIMERS];
  logic [LINK_W-1:0] head_r, head_nxt;

  // request and walk registers
  logic [KIND_W-1:0]  kind_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [TIME_W-1:0]  dlin_r;
  logic [TIME_W-1:0]  now_r;
  logic [LINK_W-1:0]  cur_r, cur_nxt;
  logic [LINK_W-1:0]  prv_r, prv_nxt;
  logic [SLOT_W-1:0]  vic_r, vic_nxt;
  logic [GUARD_W-1:0] guard_r, guard_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TIME_W-1:0]  rt_r, rt_nxt;
  logic               dl_we;

  // result registers
  logic               ov_r, ov_nxt;
  logic               oev_r, oev_nxt;
  logic [SLOT_W-1:0]  oes_r, oes_nxt;
  logic               opt_r, opt_nxt;
  logic [TIME_W-1:0]  otd_r, otd_nxt;
  logic [TIME_W-1:0]  ort_r, ort_nxt;
  logic               orf_r, orf_nxt;
  logic               olast_r, olast_nxt;

  // single read port shared by all list arrays
  logic [LINK_W-1:0] rd_addr;
  logic [SLOT_W-1:0] rd_idx;
  logic [TIME_W-1:0] dl_rd;
  logic [LINK_W-1:0] next_rd;
  logic [LINK_W-1:0] prev_rd;
  logic              act_rd;
  logic              head_ok;

  always_comb begin
    case (cmd.rd_sel)
      RD_SLOT: rd_addr = {1'b0, slot_r};
      RD_CUR:  rd_addr = cur_r;
      RD_HEAD: rd_addr = head_r;
      default: rd_addr = head_r;
    endcase
    rd_idx  = rd_addr[SLOT_W-1:0];
    dl_rd   = wr_r[rd_idx] ? dl_r[rd_idx] : '0;
    next_rd = next_r[rd_idx];
    prev_rd = prev_r[rd_idx];
    act_rd  = act_r[rd_idx];
  end

  assign head_ok = (head_r != NIL);

  always_comb begin
    stat.kind        = kind_r;
    stat.slot_ok     = ({1'b0, slot_r} < LINK_W'(NUM_TIMERS));
    stat.slot_act    = act_rd;
    stat.walk_more   = (cur_r != NIL) && (guard_r < GUARD_W'(NUM_TIMERS)) &&
                       (dl_rd < dlin_r);
    stat.expire_head = head_ok && (dl_rd <= now_r);
    stat.chain_more  = (kind_r == KIND_CHK) && head_ok &&
                       (cnt_r < CNT_W'(MAX_RESULTS - 1)) && (dl_rd <= now_r);
  end

  always_comb begin
    wr_nxt    = wr_r;
    act_nxt   = act_r;
    next_nxt  = next_r;
    prev_nxt  = prev_r;
    head_nxt  = head_r;
    cur_nxt   = cur_r;
    prv_nxt   = prv_r;
    vic_nxt   = vic_r;
    guard_nxt = guard_r;
    cnt_nxt   = cnt_r;
    rt_nxt    = rt_r;
    dl_we     = 1'b0;
    ov_nxt    = 1'b0;
    oev_nxt   = 1'b0;
    oes_nxt   = '0;
    opt_nxt   = 1'b0;
    otd_nxt   = '0;
    ort_nxt   = '0;
    orf_nxt   = 1'b0;
    olast_nxt = 1'b0;
    case (cmd.op)
      OP_LOAD: begin
        cnt_nxt = '0;
      end
      OP_EMIT_REFUSE: begin
        ov_nxt    = 1'b1;
        orf_nxt   = 1'b1;
        olast_nxt = 1'b1;
      end
      OP_EMIT_ZERO: begin
        ov_nxt    = 1'b1;
        olast_nxt = 1'b1;
      end
      OP_EMIT_HEAD: begin
        ov_nxt    = 1'b1;
        opt_nxt   = head_ok;
        otd_nxt   = head_ok ? dl_rd : '0;
        olast_nxt = 1'b1;
      end
      OP_ENQ_INIT: begin
        dl_we          = 1'b1;
        wr_nxt[slot_r] = 1'b1;
        cur_nxt        = head_r;
        prv_nxt        = NIL;
        guard_nxt      = '0;
      end
      OP_WALK_STEP: begin
        prv_nxt   = cur_r;
        cur_nxt   = next_rd;
        guard_nxt = guard_r + 1'b1;
      end
      OP_LINK_A: begin
        next_nxt[slot_r] = cur_r;
        prev_nxt[slot_r] = prv_r;
        act_nxt[slot_r]  = 1'b1;
        if (prv_r == NIL) begin
          head_nxt = {1'b0, slot_r};
        end
      end
      OP_LINK_B: begin
        if (prv_r != NIL) begin
          next_nxt[prv_r[SLOT_W-1:0]] = {1'b0, slot_r};
        end
        if (cur_r != NIL) begin
          prev_nxt[cur_r[SLOT_W-1:0]] = {1'b0, slot_r};
        end
        ov_nxt    = 1'b1;
        opt_nxt   = (prv_r == NIL);
        otd_nxt   = (prv_r == NIL) ? dlin_r : '0;
        olast_nxt = 1'b1;
      end
      OP_DEQ_IDLE: begin
        ov_nxt    = 1'b1;
        ort_nxt   = dl_rd;
        olast_nxt = 1'b1;
      end
      OP_DEQ_GRAB: begin
        vic_nxt = slot_r;
        cur_nxt = next_rd;
        prv_nxt = prev_rd;
        rt_nxt  = dl_rd;
      end
      OP_CHK_GRAB: begin
        vic_nxt = head_r[SLOT_W-1:0];
        cur_nxt = next_rd;
        prv_nxt = prev_rd;
      end
      OP_UNL_A: begin
        if (cur_r != NIL) begin
          prev_nxt[cur_r[SLOT_W-1:0]] = prv_r;
        end
        if (prv_r != NIL) begin
          next_nxt[prv_r[SLOT_W-1:0]] = cur_r;
        end else begin
          head_nxt = cur_r;
        end
        act_nxt[vic_r] = 1'b0;
      end
      OP_UNL_B: begin
        next_nxt[vic_r] = NIL;
        prev_nxt[vic_r] = NIL;
        ov_nxt          = 1'b1;
        if (kind_r == KIND_CHK) begin
          oev_nxt   = 1'b1;
          oes_nxt   = vic_r;
          opt_nxt   = head_ok;
          otd_nxt   = head_ok ? dl_rd : '0;
          olast_nxt = !stat.chain_more;
          cnt_nxt   = cnt_r + 1'b1;
          if (stat.chain_more) begin
            vic_nxt = head_r[SLOT_W-1:0];
            cur_nxt = next_rd;
            prv_nxt = prev_rd;
          end
        end else begin
          opt_nxt   = (prv_r == NIL) && head_ok;
          otd_nxt   = ((prv_r == NIL) && head_ok) ? dl_rd : '0;
          ort_nxt   = rt_r;
          olast_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      act_r   <= '0;
      head_r  <= NIL;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        next_r[i] <= NIL;
        prev_r[i] <= NIL;
      end
    end else begin
      wr_r    <= wr_nxt;
      act_r   <= act_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      next_r  <= next_nxt;
      prev_r  <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      kind_r <= in_kind;
      slot_r <= in_slot;
      dlin_r <= in_deadline;
      now_r  <= in_now;
    end
    if (dl_we) begin
      dl_r[slot_r] <= dlin_r;
    end
    cur_r   <= cur_nxt;
    prv_r   <= prv_nxt;
    vic_r   <= vic_nxt;
    guard_r <= guard_nxt;
    rt_r    <= rt_nxt;
    oev_r   <= oev_nxt;
    oes_r   <= oes_nxt;
    opt_r   <= opt_nxt;
    otd_r   <= otd_nxt;
    ort_r   <= ort_nxt;
    orf_r   <= orf_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid          = ov_r;
  assign out_expired_valid  = oev_r;
  assign out_expired_slot   = oes_r;
  assign out_program_timer  = opt_r;
  assign out_timer_deadline = otd_r;
  assign out_removed_time   = ort_r;
  assign out_refused        = orf_r;
  assign out_last           = olast_r;

  a_head_active: assert property (@(posedge clk) disable iff (!rst_n)
    head_r != NIL |-> act_r[head_r[SLOT_W-1:0]])
    else $error("list head is not an active slot");

  a_walk_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_WALK_STEP |-> cur_r != NIL && act_r[cur_r[SLOT_W-1:0]])
    else $error("walk stepped past the list");

  a_chain_next: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !olast_r |-> oev_r ##2 (ov_r && oev_r))
    else $error("expiry chain broke before its last request");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("expiry count overran");

endmodule

### rtl/sorted_deadline_timer_queue.sv
// top level of the sorted deadline timer queue
// one request at a time: busy stays high until the request's last result is issued,
//   the pace set by the one-entry-per-cycle walk and two-step unlink of the linked list
// reset (rst_n low, synchronous) empties the list, idles all slots, zeroes stored times
// results strobe on out_valid for one cycle each; the receiver cannot stall
module sorted_deadline_timer_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [sdtq_pkg::KIND_W-1:0]  in_kind,
  input  logic [sdtq_pkg::SLOT_W-1:0]  in_slot,
  input  logic [sdtq_pkg::TIME_W-1:0]  in_deadline,
  input  logic [sdtq_pkg::TIME_W-1:0]  in_now,
  output logic                         out_valid,
  output logic                         out_expired_valid,
  output logic [sdtq_pkg::SLOT_W-1:0]  out_expired_slot,
  output logic                         out_program_timer,
  output logic [sdtq_pkg::TIME_W-1:0]  out_timer_deadline,
  output logic [sdtq_pkg::TIME_W-1:0]  out_removed_time,
  output logic                         out_refused,
  output logic                         out_last
);
  import sdtq_pkg::*;

  // command and status between the sequencer and the list datapath
  sdtq_cmd_t  cmd;
  sdtq_stat_t stat;

  // sequencer: decodes the request kind, runs the sorted walk on enqueue
  // and the two-step unlink used by dequeue and by each expiry of a check
  sdtq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath: slot times, active flags, doubly linked list, one shared
  // read port, and the registered result fields
  sdtq_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_kind            (in_kind),
    .in_slot            (in_slot),
    .in_deadline        (in_deadline),
    .in_now             (in_now),
    .out_valid          (out_valid),
    .out_expired_valid  (out_expired_valid),
    .out_expired_slot   (out_expired_slot),
    .out_program_timer  (out_program_timer),
    .out_timer_deadline (out_timer_deadline),
    .out_removed_time   (out_removed_time),
    .out_refused        (out_refused),
    .out_last           (out_last)
  );

endmodule
